// ----- hdl/rv32d_pkg.sv -----
// Package for the RV32 subset instruction decoder.
// Holds the major opcodes, the operation numbers and the decoded result type.
// No dependencies.
package rv32d_pkg;

  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcSystem = 7'h73;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcJal    = 7'h6f;

  localparam logic [11:0] ShiftHiMask = 12'hfe0;
  localparam logic [11:0] ShamtMask   = 12'h01f;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_MUL   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SLL   = 5'd3,
    OP_MULH  = 5'd4,
    OP_SLT   = 5'd5,
    OP_XOR   = 5'd6,
    OP_DIV   = 5'd7,
    OP_SRL   = 5'd8,
    OP_SRA   = 5'd9,
    OP_OR    = 5'd10,
    OP_REM   = 5'd11,
    OP_AND   = 5'd12,
    OP_ADDI  = 5'd13,
    OP_SLLI  = 5'd14,
    OP_SLTI  = 5'd15,
    OP_XORI  = 5'd16,
    OP_SRLI  = 5'd17,
    OP_SRAI  = 5'd18,
    OP_ORI   = 5'd19,
    OP_ANDI  = 5'd20,
    OP_LB    = 5'd21,
    OP_LH    = 5'd22,
    OP_LW    = 5'd23,
    OP_SB    = 5'd24,
    OP_SH    = 5'd25,
    OP_SW    = 5'd26,
    OP_BEQ   = 5'd27,
    OP_BNE   = 5'd28,
    OP_LUI   = 5'd29,
    OP_JAL   = 5'd30,
    OP_ECALL = 5'd31
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               invalid;
    logic [4:0]         rd;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic signed [31:0] imm;
  } dec_result_t;

endpackage

// ----- hdl/rv32d_decode.sv -----
// Combinational decode of one instruction word into a dec_result_t.
// Depends on rv32d_pkg for the opcodes, operation numbers and result type.
module rv32d_decode
  import rv32d_pkg::*;
(
  input  logic [31:0] word_i,
  output dec_result_t result_o
);

  logic [6:0]         opc;
  logic [2:0]         f3;
  logic [6:0]         f7;
  logic [11:0]        i12;
  logic signed [31:0] iimm;
  logic signed [31:0] simm;
  logic signed [31:0] bimm;
  logic signed [31:0] jimm;
  logic               alt;

  assign opc  = word_i[6:0];
  assign f3   = word_i[14:12];
  assign f7   = word_i[31:25];
  assign i12  = word_i[31:20];
  assign alt  = (f7 != 7'd0);
  assign iimm = {{20{word_i[31]}}, word_i[31:20]};
  assign simm = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign bimm = {{20{word_i[31]}}, word_i[7], word_i[30:25], word_i[11:8], 1'b0};
  assign jimm = {{12{word_i[31]}}, word_i[19:12], word_i[20], word_i[30:21], 1'b0};

  always_comb begin
    result_o.op      = OP_ADD;
    result_o.invalid = 1'b1;
    result_o.rd      = 5'd0;
    result_o.rs1     = 5'd0;
    result_o.rs2     = 5'd0;
    result_o.imm     = 32'sd0;
    case (opc)
      OpcOp: begin
        result_o.invalid = 1'b0;
        case (f3)
          3'd0: begin
            if (f7 == 7'd0) begin
              result_o.op = OP_ADD;
            end else if (f7 == 7'd1) begin
              result_o.op = OP_MUL;
            end else begin
              result_o.op = OP_SUB;
            end
          end
          3'd1: result_o.op = alt ? OP_MULH : OP_SLL;
          3'd2: result_o.op = OP_SLT;
          3'd4: result_o.op = alt ? OP_DIV : OP_XOR;
          3'd5: result_o.op = alt ? OP_SRA : OP_SRL;
          3'd6: result_o.op = alt ? OP_REM : OP_OR;
          3'd7: result_o.op = OP_AND;
          default: result_o.invalid = 1'b1;
        endcase
        if (!result_o.invalid) begin
          result_o.rd  = word_i[11:7];
          result_o.rs1 = word_i[19:15];
          result_o.rs2 = word_i[24:20];
        end
      end
      OpcOpImm: begin
        result_o.invalid = 1'b0;
        result_o.imm     = iimm;
        case (f3)
          3'd0: result_o.op = OP_ADDI;
          3'd1: result_o.op = OP_SLLI;
          3'd2: result_o.op = OP_SLTI;
          3'd4: result_o.op = OP_XORI;
          3'd5: begin
            result_o.op  = ((i12 & ShiftHiMask) == 12'd0) ? OP_SRLI : OP_SRAI;
            result_o.imm = {20'd0, i12 & ShamtMask};
          end
          3'd6: result_o.op = OP_ORI;
          3'd7: result_o.op = OP_ANDI;
          default: begin
            result_o.invalid = 1'b1;
            result_o.imm     = 32'sd0;
          end
        endcase
        if (!result_o.invalid) begin
          result_o.rd  = word_i[11:7];
          result_o.rs1 = word_i[19:15];
        end
      end
      OpcLoad: begin
        if (f3 <= 3'd2) begin
          result_o.invalid = 1'b0;
          result_o.op      = op_e'(5'(OP_LB) + {2'd0, f3});
          result_o.rd      = word_i[11:7];
          result_o.rs1     = word_i[19:15];
          result_o.imm     = iimm;
        end
      end
      OpcStore: begin
        if (f3 <= 3'd2) begin
          result_o.invalid = 1'b0;
          result_o.op      = op_e'(5'(OP_SB) + {2'd0, f3});
          result_o.rs1     = word_i[19:15];
          result_o.rs2     = word_i[24:20];
          result_o.imm     = simm;
        end
      end
      OpcBranch: begin
        if (f3 <= 3'd1) begin
          result_o.invalid = 1'b0;
          result_o.op      = f3[0] ? OP_BNE : OP_BEQ;
          result_o.rs1     = word_i[19:15];
          result_o.rs2     = word_i[24:20];
          result_o.imm     = bimm;
        end
      end
      OpcLui: begin
        result_o.invalid = 1'b0;
        result_o.op      = OP_LUI;
        result_o.rd      = word_i[11:7];
        result_o.imm     = {12'd0, word_i[31:12]};
      end
      OpcJal: begin
        result_o.invalid = 1'b0;
        result_o.op      = OP_JAL;
        result_o.rd      = word_i[11:7];
        result_o.imm     = jimm;
      end
      OpcSystem: begin
        result_o.invalid = 1'b0;
        result_o.op      = OP_ECALL;
      end
      default: result_o.invalid = 1'b1;
    endcase
  end

endmodule

// ----- hdl/rv32_subset_instruction_decoder.sv -----
// Top level of the RV32 subset instruction decoder: input register, decode, result register.
// Depends on rv32d_pkg and rv32d_decode.
// An accepted word passes the input register, then the decode, then the result register.
// Throughput is one transaction per cycle unless stall_i holds; an empty stage still fills.
// Reset clears both stage valid flags; the payload registers are not reset.
module rv32_subset_instruction_decoder
  import rv32d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [31:0]        instr_word_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [4:0]         op_code_o,
  output logic               invalid_o,
  output logic [4:0]         rd_o,
  output logic [4:0]         rs1_o,
  output logic [4:0]         rs2_o,
  output logic signed [31:0] imm_o
);

  logic        in_valid_q;
  logic        in_valid_d;
  logic [31:0] word_q;
  logic        out_valid_q;
  logic        out_valid_d;
  dec_result_t result_q;
  dec_result_t result_d;
  logic        out_advance;
  logic        in_advance;

  assign out_advance = !out_valid_q || !stall_i;
  assign in_advance  = !in_valid_q || out_advance;
  assign stall_o     = !in_advance;

  assign in_valid_d  = in_advance ? valid_i : in_valid_q;
  assign out_valid_d = out_advance ? in_valid_q : out_valid_q;

  rv32d_decode u_decode (
    .word_i   (word_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && valid_i) begin
      word_q <= instr_word_i;
    end
    if (out_advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign valid_o   = out_valid_q;
  assign op_code_o = result_q.op;
  assign invalid_o = result_q.invalid;
  assign rd_o      = result_q.rd;
  assign rs1_o     = result_q.rs1;
  assign rs2_o     = result_q.rs2;
  assign imm_o     = result_q.imm;

endmodule

// ----- tb/rv32d_decode_checker.sv -----
// Checker for the RV32 subset instruction decoder: watches both channels, predicts each
// decode from the accepted instruction word and compares it with the returned result.
// Depends on rv32d_pkg for the opcodes, operation numbers and the result type.
module rv32d_decode_checker
  import rv32d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [31:0]        instr_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [4:0]         op_code_i,
  input  logic               invalid_i,
  input  logic [4:0]         rd_i,
  input  logic [4:0]         rs1_i,
  input  logic [4:0]         rs2_i,
  input  logic signed [31:0] imm_i,
  output int                 fail_count_o,
  output int                 outstanding_o,
  output int                 checked_o,
  output int                 flagged_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Shr  = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3Byte = 3'd0;
  localparam logic [2:0] F3Half = 3'd1;
  localparam logic [2:0] F3Word = 3'd2;
  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [6:0] F7Base   = 7'h00;
  localparam logic [6:0] F7MulDiv = 7'h01;

  dec_result_t expected_decodes[$];

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    checked_o     = 0;
    flagged_o     = 0;
  end

  function automatic dec_result_t predict_decode(input logic [31:0] w);
    dec_result_t        d;
    logic               bad;
    logic [6:0]         f7;
    logic [2:0]         f3;
    logic signed [31:0] i_imm;
    logic [12:0]        b_off;
    logic [20:0]        j_off;
    d     = '0;
    bad   = 1'b0;
    f7    = w[31:25];
    f3    = w[14:12];
    i_imm = {{20{w[31]}}, w[31:20]};
    b_off = {w[31], w[7], w[30:25], w[11:8], 1'b0};
    j_off = {w[31], w[19:12], w[20], w[30:21], 1'b0};
    case (w[6:0])
      OpcOp: begin
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        case (f3)
          F3Add: begin
            if (f7 == F7Base) d.op = OP_ADD;
            else if (f7 == F7MulDiv) d.op = OP_MUL;
            else d.op = OP_SUB;
          end
          F3Sll:  d.op = (f7 != F7Base) ? OP_MULH : OP_SLL;
          F3Slt:  d.op = OP_SLT;
          F3Sltu: bad = 1'b1;
          F3Xor:  d.op = (f7 != F7Base) ? OP_DIV : OP_XOR;
          F3Shr:  d.op = (f7 != F7Base) ? OP_SRA : OP_SRL;
          F3Or:   d.op = (f7 != F7Base) ? OP_REM : OP_OR;
          default: d.op = OP_AND;
        endcase
      end
      OpcOpImm: begin
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.imm = i_imm;
        case (f3)
          F3Add:  d.op = OP_ADDI;
          F3Sll:  d.op = OP_SLLI;
          F3Slt:  d.op = OP_SLTI;
          F3Sltu: bad = 1'b1;
          F3Xor:  d.op = OP_XORI;
          F3Shr: begin
            d.op  = (f7 == F7Base) ? OP_SRLI : OP_SRAI;
            d.imm = {27'd0, w[24:20]};
          end
          F3Or:   d.op = OP_ORI;
          default: d.op = OP_ANDI;
        endcase
      end
      OpcLoad: begin
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.imm = i_imm;
        case (f3)
          F3Byte: d.op = OP_LB;
          F3Half: d.op = OP_LH;
          F3Word: d.op = OP_LW;
          default: bad = 1'b1;
        endcase
      end
      OpcStore: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          F3Byte: d.op = OP_SB;
          F3Half: d.op = OP_SH;
          F3Word: d.op = OP_SW;
          default: bad = 1'b1;
        endcase
      end
      OpcBranch: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{19{b_off[12]}}, b_off};
        case (f3)
          F3Beq: d.op = OP_BEQ;
          F3Bne: d.op = OP_BNE;
          default: bad = 1'b1;
        endcase
      end
      OpcLui: begin
        d.op  = OP_LUI;
        d.rd  = w[11:7];
        d.imm = {12'd0, w[31:12]};
      end
      OpcJal: begin
        d.op  = OP_JAL;
        d.rd  = w[11:7];
        d.imm = {{11{j_off[20]}}, j_off};
      end
      OpcSystem: d.op = OP_ECALL;
      default: bad = 1'b1;
    endcase
    if (bad) begin
      d         = '0;
      d.invalid = 1'b1;
    end
    return d;
  endfunction

  function automatic bit field_ok(input string name, input logic signed [31:0] want,
                                  input logic signed [31:0] got);
    if (got !== want) begin
      $display("%t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    dec_result_t want;
    bit          good;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_decodes.size() == 0) begin
          $display("%t: unexpected result, expected none, actual op %0d imm %0d", $time,
                   op_code_i, imm_i);
          fail_count_o++;
        end else begin
          want = expected_decodes.pop_front();
          good = field_ok("op_code", want.op, op_code_i);
          good = field_ok("invalid", want.invalid, invalid_i) && good;
          good = field_ok("rd", want.rd, rd_i) && good;
          good = field_ok("rs1", want.rs1, rs1_i) && good;
          good = field_ok("rs2", want.rs2, rs2_i) && good;
          good = field_ok("imm", want.imm, imm_i) && good;
          if (!good) fail_count_o++;
          if (want.invalid) flagged_o++;
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) expected_decodes.push_back(predict_decode(instr_word_i));
      outstanding_o <= expected_decodes.size();
    end
  end

endmodule

// ----- tb/tb_rv32_subset_instruction_decoder.sv -----
// Testbench top for the RV32 subset instruction decoder: clock, reset, instruction stimulus
// with random sender gaps and receiver stalls, watchdog and verdict.
// Depends on rv32d_pkg, the decoder RTL and rv32d_decode_checker.
module tb_rv32_subset_instruction_decoder
  import rv32d_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 11;
  localparam int RandomItems   = 1500;
  localparam int PhaseCount    = 6;
  localparam int DrainCycles   = 10;
  localparam int WatchdogLimit = 2000;

  localparam logic [6:0] F7MulDiv     = 7'h01;
  localparam logic [6:0] F7ShiftArith = 7'h20;

  localparam logic [6:0] MajorOpcodes [8] = '{
    OpcOp, OpcLoad, OpcOpImm, OpcSystem, OpcStore, OpcBranch, OpcLui, OpcJal
  };

  localparam logic [31:0] DirectedWords [27] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0033, 32'hFFFF_8FB3, 32'h0220_81B3,
    32'hFFFF_BFB3, 32'hFFFF_AFB3, 32'h4073_52B3, 32'hFFFF_8F93, 32'h7FF0_0093,
    32'hFFFF_9F93, 32'h01F1_5093, 32'h4001_5093, 32'h0231_5093, 32'hFFFF_BF93,
    32'h8001_2083, 32'hFFFF_BF83, 32'hFFFF_AFA3, 32'h0011_4023, 32'h8000_0063,
    32'hFFFF_9FE3, 32'h0000_2063, 32'hFFFF_FFB7, 32'hFFFF_FFEF, 32'h7FFF_FFEF,
    32'hFFFF_FF73, 32'h0000_0073
  };

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               valid_i      = 1'b0;
  logic [31:0]        instr_word_i = '0;
  logic               stall_i      = 1'b0;
  logic               stall_o;
  logic               valid_o;
  logic [4:0]         op_code_o;
  logic               invalid_o;
  logic [4:0]         rd_o;
  logic [4:0]         rs1_o;
  logic [4:0]         rs2_o;
  logic signed [31:0] imm_o;

  int fail_count;
  int outstanding;
  int checked;
  int flagged;
  int words_sent  = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  rv32_subset_instruction_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .instr_word_i (instr_word_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .op_code_o    (op_code_o),
    .invalid_o    (invalid_o),
    .rd_o         (rd_o),
    .rs1_o        (rs1_o),
    .rs2_o        (rs2_o),
    .imm_o        (imm_o)
  );

  rv32d_decode_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (valid_i),
    .in_stall_i    (stall_o),
    .instr_word_i  (instr_word_i),
    .out_valid_i   (valid_o),
    .out_stall_i   (stall_i),
    .op_code_i     (op_code_o),
    .invalid_i     (invalid_o),
    .rd_i          (rd_o),
    .rs1_i         (rs1_o),
    .rs2_i         (rs2_o),
    .imm_i         (imm_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .flagged_o     (flagged)
  );

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 99) < 85) begin
      w[6:0] = MajorOpcodes[$urandom_range(0, 7)];
      if (w[6:0] == OpcOp || w[6:0] == OpcOpImm) begin
        case ($urandom_range(0, 2))
          0: w[31:25] = '0;
          1: w[31:25] = (w[6:0] == OpcOp) ? F7MulDiv : F7ShiftArith;
          default: ;
        endcase
      end
      if ((w[6:0] == OpcLoad || w[6:0] == OpcStore) && $urandom_range(0, 3) != 0) begin
        w[14:12] = 3'($urandom_range(0, 2));
      end
      if (w[6:0] == OpcBranch && $urandom_range(0, 3) != 0) begin
        w[14:12] = 3'($urandom_range(0, 1));
      end
    end
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w);
    int gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? int'($urandom_range(1, 19)) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    words_sent++;
  endtask

  task automatic drain_decoder();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    int hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = ($urandom_range(0, 99) < rx_idle_pct) ? int'($urandom_range(1, 19)) : 0;
      if (hold > 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DirectedWords[i]) send_word(DirectedWords[i]);
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 40; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 40; end
        3: begin tx_idle_pct = 90; rx_idle_pct = 90; end
        4: begin tx_idle_pct = 20; rx_idle_pct = 20; end
        default: begin
          tx_idle_pct = $urandom_range(0, 100);
          rx_idle_pct = $urandom_range(0, 100);
        end
      endcase
      for (int n = 0; n < RandomItems / PhaseCount; n++) send_word(random_word());
      if (phase == 2) drain_decoder();
    end
    drain_decoder();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d instruction words and checked %0d decodes, %0d flagged invalid.",
             words_sent, checked, flagged);
    $display("Gaps and stalls ran from none to heavy, with one full drain mid-run.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
